[rtl/page_replacement_clock_fifo_top_macros.svh]
// assertion macros used by the frame table sequencer
`ifndef PAGE_REPLACEMENT_CLOCK_FIFO_TOP_MACROS_SVH
`define PAGE_REPLACEMENT_CLOCK_FIFO_TOP_MACROS_SVH

// same-cycle implication, checked while out of reset
`define PRCF_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("prcf check failed");

// next-cycle implication, checked while out of reset
`define PRCF_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("prcf check failed");

`endif

[rtl/prcf_pkg.sv]
// shared types and constants of the page frame table
`default_nettype none

package prcf_pkg;

    localparam int PAGE_W  = 8;   // page id field on the item channels
    localparam int FRAME_W = 6;   // frame index field on the result channel
    localparam int PADDR_W = 3;
    localparam int DATA_W  = 32;

    // register index, taken from paddr bit 2
    localparam logic REG_POLICY = 1'b0;

    // replacement policy codes
    localparam logic POLICY_FIFO  = 1'b0;
    localparam logic POLICY_CLOCK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LK_RD,
        ST_LK_EV,
        ST_SW_RD,
        ST_SW_EV,
        ST_CL_RD,
        ST_CL_EV
    } prcf_state_t;

    typedef struct packed {
        logic referenced;
        logic modified;
    } prcf_flags_t;

    typedef struct packed {
        logic        wr_en;
        prcf_flags_t flags;
    } prcf_wr_cmd_t;

endpackage

`default_nettype wire

[rtl/prcf_if.sv]
// item channel interfaces for access items and result items
`default_nettype none

interface prcf_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [prcf_pkg::PAGE_W-1:0] page_id;
    logic                       is_write;

    modport source (output valid, mode, page_id, is_write, input ready);
    modport sink (input valid, mode, page_id, is_write, output ready);
endinterface

interface prcf_out_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [prcf_pkg::FRAME_W-1:0] frame;
    logic                        evicted_valid;
    logic [prcf_pkg::PAGE_W-1:0]  evicted_page;
    logic                        evicted_dirty;

    modport source (output valid, hit, frame, evicted_valid, evicted_page, evicted_dirty,
                    input ready);
    modport sink (input valid, hit, frame, evicted_valid, evicted_page, evicted_dirty,
                  output ready);
endinterface

`default_nettype wire

[rtl/page_replacement_clock_fifo_top.sv]
// top level of the page frame table with fifo or clock replacement
// sequence: a lookup reads and compares frames from frame 0 up to a hit at frame k;
//   a miss then sweeps from the clock hand frame by frame to the victim; a clear
//   item visits every frame; a finishing step waits while a result is pending
// throughput: one item at a time, set by the single table read port that the
//   sequencer visits per frame in a read step, then a compare and write-back step
// reset: async active low; frames read as page k+1 with both bits clear, hand 0,
//   policy clock; per-frame valid bits stand in for the contents, no clearing pass
`default_nettype none

module page_replacement_clock_fifo_top #(
    parameter int FRAMES       = 64,
    parameter int PAGE_ID_BITS = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    prcf_in_if.sink                           access,
    prcf_out_if.source                        result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [prcf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [prcf_pkg::DATA_W-1:0]  pwdata,
    output logic      [prcf_pkg::DATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int AW = $clog2(FRAMES);

    // policy register: the user must write it only while no item is in flight; not enforced
    logic policy;

    // frame table access: one address shared by read and write-back
    logic [AW-1:0]           tbl_addr;
    prcf_pkg::prcf_wr_cmd_t  tbl_cmd;
    logic [PAGE_ID_BITS-1:0] tbl_wr_page;
    logic [PAGE_ID_BITS-1:0] tbl_rd_page;
    prcf_pkg::prcf_flags_t   tbl_rd_flags;

    prcf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .policy  (policy)
    );

    // page, modified and referenced bits per frame; read data is registered
    prcf_table #(
        .FRAMES       (FRAMES),
        .PAGE_ID_BITS (PAGE_ID_BITS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .addr     (tbl_addr),
        .cmd      (tbl_cmd),
        .wr_page  (tbl_wr_page),
        .rd_page  (tbl_rd_page),
        .rd_flags (tbl_rd_flags)
    );

    // sequencer: linear lookup from frame 0, then a clock sweep from the hand
    // on a miss (fifo takes the hand frame at once), or a clear sweep; the
    // result register lets a new item in while the last result waits
    prcf_seq #(
        .FRAMES       (FRAMES),
        .PAGE_ID_BITS (PAGE_ID_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .policy       (policy),
        .access       (access),
        .result       (result),
        .tbl_addr     (tbl_addr),
        .tbl_cmd      (tbl_cmd),
        .tbl_wr_page  (tbl_wr_page),
        .tbl_rd_page  (tbl_rd_page),
        .tbl_rd_flags (tbl_rd_flags)
    );

endmodule

`default_nettype wire

[rtl/prcf_cfg.sv]
// apb register block holding the replacement policy
`default_nettype none

module prcf_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [prcf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [prcf_pkg::DATA_W-1:0]  pwdata,
    output logic      [prcf_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output logic                              policy
);

    logic policy_reg;
    logic policy_next;
    logic hit_policy;

    assign hit_policy = (paddr[prcf_pkg::PADDR_W-1] == prcf_pkg::REG_POLICY);

    always_comb
    begin
        policy_next = policy_reg;
        if (psel && penable && pwrite && hit_policy)
        begin
            policy_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= prcf_pkg::POLICY_CLOCK;
        end
        else
        begin
            policy_reg <= policy_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit_policy)
        begin
            prdata[0] = policy_reg;
        end
    end

    assign pready = 1'b1;
    assign policy = policy_reg;

endmodule

`default_nettype wire

[rtl/prcf_table.sv]
// frame table memory with per-frame valid bits standing in for the reset contents
`default_nettype none

module prcf_table #(
    parameter int FRAMES       = 64,
    parameter int PAGE_ID_BITS = 8,
    localparam int AW          = $clog2(FRAMES)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [AW-1:0]                addr,
    input  wire prcf_pkg::prcf_wr_cmd_t       cmd,
    input  wire logic [PAGE_ID_BITS-1:0]      wr_page,
    output logic      [PAGE_ID_BITS-1:0]      rd_page,
    output prcf_pkg::prcf_flags_t             rd_flags
);

    localparam int WW = PAGE_ID_BITS + 2;

    logic [WW-1:0]     entry_mem [FRAMES];
    logic [FRAMES-1:0] valid_reg;
    logic [FRAMES-1:0] valid_next;
    logic [WW-1:0]     rd_word_reg;
    logic              rd_valid_reg;
    logic [AW-1:0]     rd_addr_reg;
    logic [AW:0]       reset_page;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            entry_mem[addr] <= {wr_page, cmd.flags.modified, cmd.flags.referenced};
        end
        rd_word_reg  <= entry_mem[addr];
        rd_valid_reg <= valid_reg[addr];
        rd_addr_reg  <= addr;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.wr_en)
        begin
            valid_next[addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // an unwritten frame k holds page k plus one, both bits clear
    assign reset_page = {1'b0, rd_addr_reg} + {{AW{1'b0}}, 1'b1};

    assign rd_page             = rd_valid_reg ? rd_word_reg[WW-1:2]
                                              : PAGE_ID_BITS'(reset_page);
    assign rd_flags.modified   = rd_valid_reg & rd_word_reg[1];
    assign rd_flags.referenced = rd_valid_reg & rd_word_reg[0];

endmodule

`default_nettype wire

[rtl/prcf_seq.sv]
// sequencer that walks the frame table with one shared page comparator
`default_nettype none
`include "page_replacement_clock_fifo_top_macros.svh"

module prcf_seq #(
    parameter int FRAMES       = 64,
    parameter int PAGE_ID_BITS = 8,
    localparam int AW          = $clog2(FRAMES)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    policy,
    prcf_in_if.sink                      access,
    prcf_out_if.source                   result,
    output logic      [AW-1:0]           tbl_addr,
    output prcf_pkg::prcf_wr_cmd_t       tbl_cmd,
    output logic      [PAGE_ID_BITS-1:0] tbl_wr_page,
    input  wire logic [PAGE_ID_BITS-1:0] tbl_rd_page,
    input  wire prcf_pkg::prcf_flags_t   tbl_rd_flags
);

    localparam int FW = prcf_pkg::FRAME_W;
    localparam int PW = prcf_pkg::PAGE_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(FRAMES - 1);

    prcf_pkg::prcf_state_t state_reg, state_next;

    logic [AW-1:0]           idx_reg, idx_next;
    logic [AW-1:0]           hand_reg, hand_next;
    logic [PAGE_ID_BITS-1:0] page_reg, page_next;
    logic                    wr_reg, wr_next;

    logic          out_valid_reg, out_valid_next;
    logic          hit_reg, hit_next;
    logic [FW-1:0] frame_reg, frame_next;
    logic          ev_valid_reg, ev_valid_next;
    logic [PW-1:0] ev_page_reg, ev_page_next;
    logic          ev_dirty_reg, ev_dirty_next;

    logic          match;
    logic          last;
    logic          victim;
    logic          fin_ok;
    logic [AW-1:0] idx_inc;
    logic          ev_state;

    // shared compare unit and index stepping
    assign match   = (tbl_rd_page == page_reg);
    assign last    = (idx_reg == LAST_IDX);
    assign idx_inc = last ? '0 : idx_reg + {{(AW-1){1'b0}}, 1'b1};
    assign victim  = (policy == prcf_pkg::POLICY_FIFO) || !tbl_rd_flags.referenced;
    assign fin_ok  = !out_valid_reg || result.ready;

    // evaluation steps: read data valid, compare and write back
    assign ev_state = (state_reg == prcf_pkg::ST_LK_EV) || (state_reg == prcf_pkg::ST_SW_EV)
                      || (state_reg == prcf_pkg::ST_CL_EV);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            prcf_pkg::ST_IDLE:
            begin
                if (access.valid)
                begin
                    state_next = access.mode ? prcf_pkg::ST_CL_RD : prcf_pkg::ST_LK_RD;
                end
            end
            prcf_pkg::ST_LK_RD:
            begin
                state_next = prcf_pkg::ST_LK_EV;
            end
            prcf_pkg::ST_LK_EV:
            begin
                if (match)
                begin
                    if (fin_ok)
                    begin
                        state_next = prcf_pkg::ST_IDLE;
                    end
                end
                else if (last)
                begin
                    state_next = prcf_pkg::ST_SW_RD;
                end
                else
                begin
                    state_next = prcf_pkg::ST_LK_RD;
                end
            end
            prcf_pkg::ST_SW_RD:
            begin
                state_next = prcf_pkg::ST_SW_EV;
            end
            prcf_pkg::ST_SW_EV:
            begin
                if (!victim)
                begin
                    state_next = prcf_pkg::ST_SW_RD;
                end
                else if (fin_ok)
                begin
                    state_next = prcf_pkg::ST_IDLE;
                end
            end
            prcf_pkg::ST_CL_RD:
            begin
                state_next = prcf_pkg::ST_CL_EV;
            end
            prcf_pkg::ST_CL_EV:
            begin
                if (!last)
                begin
                    state_next = prcf_pkg::ST_CL_RD;
                end
                else if (fin_ok)
                begin
                    state_next = prcf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = prcf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        access.ready                = (state_reg == prcf_pkg::ST_IDLE);
        tbl_cmd.wr_en               = 1'b0;
        tbl_cmd.flags.referenced    = 1'b0;
        tbl_cmd.flags.modified      = tbl_rd_flags.modified;
        tbl_wr_page                 = tbl_rd_page;
        case (state_reg)
            prcf_pkg::ST_LK_EV:
            begin
                if (match && fin_ok)
                begin
                    tbl_cmd.wr_en            = 1'b1;
                    tbl_cmd.flags.referenced = 1'b1;
                    tbl_cmd.flags.modified   = tbl_rd_flags.modified | wr_reg;
                end
            end
            prcf_pkg::ST_SW_EV:
            begin
                if (!victim)
                begin
                    tbl_cmd.wr_en = 1'b1;
                end
                else if (fin_ok)
                begin
                    tbl_cmd.wr_en            = 1'b1;
                    tbl_cmd.flags.referenced = 1'b1;
                    tbl_cmd.flags.modified   = wr_reg;
                    tbl_wr_page              = page_reg;
                end
            end
            prcf_pkg::ST_CL_EV:
            begin
                tbl_cmd.wr_en = !last || fin_ok;
            end
            default:
            begin
                tbl_cmd.wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        hand_next      = hand_reg;
        page_next      = page_reg;
        wr_next        = wr_reg;
        out_valid_next = out_valid_reg && !result.ready;
        hit_next       = hit_reg;
        frame_next     = frame_reg;
        ev_valid_next  = ev_valid_reg;
        ev_page_next   = ev_page_reg;
        ev_dirty_next  = ev_dirty_reg;
        case (state_reg)
            prcf_pkg::ST_IDLE:
            begin
                if (access.valid)
                begin
                    page_next = PAGE_ID_BITS'(access.page_id);
                    wr_next   = access.is_write;
                    idx_next  = '0;
                end
            end
            prcf_pkg::ST_LK_EV:
            begin
                if (match)
                begin
                    if (fin_ok)
                    begin
                        out_valid_next = 1'b1;
                        hit_next       = 1'b1;
                        frame_next     = FW'(idx_reg);
                        ev_valid_next  = 1'b0;
                        ev_page_next   = '0;
                        ev_dirty_next  = 1'b0;
                    end
                end
                else if (last)
                begin
                    // miss: replacement starts at the hand
                    idx_next = hand_reg;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            prcf_pkg::ST_SW_EV:
            begin
                if (!victim)
                begin
                    idx_next = idx_inc;
                end
                else if (fin_ok)
                begin
                    hand_next      = idx_inc;
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    frame_next     = FW'(idx_reg);
                    ev_valid_next  = 1'b1;
                    ev_page_next   = PW'(tbl_rd_page);
                    ev_dirty_next  = tbl_rd_flags.modified;
                end
            end
            prcf_pkg::ST_CL_EV:
            begin
                if (!last)
                begin
                    idx_next = idx_inc;
                end
                else if (fin_ok)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    frame_next     = '0;
                    ev_valid_next  = 1'b0;
                    ev_page_next   = '0;
                    ev_dirty_next  = 1'b0;
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prcf_pkg::ST_IDLE;
            hand_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hand_reg      <= hand_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        page_reg     <= page_next;
        wr_reg       <= wr_next;
        hit_reg      <= hit_next;
        frame_reg    <= frame_next;
        ev_valid_reg <= ev_valid_next;
        ev_page_reg  <= ev_page_next;
        ev_dirty_reg <= ev_dirty_next;
    end

    assign tbl_addr             = idx_reg;
    assign result.valid         = out_valid_reg;
    assign result.hit           = hit_reg;
    assign result.frame         = frame_reg;
    assign result.evicted_valid = ev_valid_reg;
    assign result.evicted_page  = ev_page_reg;
    assign result.evicted_dirty = ev_dirty_reg;

    // a hit never reports an eviction
    `PRCF_ASSERT_NOW(a_hit_no_evict, clk, rst_n, out_valid_reg && hit_reg, !ev_valid_reg)
    // the hand only moves when a victim is replaced
    `PRCF_ASSERT_NEXT(a_hand_hold, clk, rst_n, state_reg != prcf_pkg::ST_SW_EV, $stable(hand_reg))
    // table writes come only from evaluation steps
    `PRCF_ASSERT_NOW(a_wr_state, clk, rst_n, tbl_cmd.wr_en, ev_state)
    // a fresh result is produced only by a finishing evaluation step
    `PRCF_ASSERT_NOW(a_res_src, clk, rst_n, out_valid_reg && !$past(out_valid_reg), $past(ev_state))

endmodule

`default_nettype wire
